@@ hdl/hill_cipher_encrypt_macros.svh @@
// assertion macros for the hill cipher encryption block
// expects signals clk and arst_n in the scope of each use
`ifndef HILL_CIPHER_ENCRYPT_MACROS_SVH
`define HILL_CIPHER_ENCRYPT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked at every rising edge out of reset
`define HCE_ASSERT_IMP(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("hill cipher assertion failed");

// next-cycle implication
`define HCE_ASSERT_NXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("hill cipher assertion failed");

`else

`define HCE_ASSERT_IMP(label, cond, prop)
`define HCE_ASSERT_NXT(label, cond, prop)

`endif

`endif

@@ hdl/hce_pkg.sv @@
// shared types, constants and the mod 26 reduction for the hill cipher block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hce_pkg;

	localparam int LETTER_W   = 7;
	localparam int VAL_W      = 5;
	localparam int KEY_W      = 45;
	localparam int ROW_W      = 3 * VAL_W;
	localparam int SUM_W      = 12;
	localparam int BSIZE_W    = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MATRIX = 2'd1;

	localparam logic [BSIZE_W-1:0]  BSIZE_TWO    = 2'd2;
	localparam logic [BSIZE_W-1:0]  BSIZE_RESET  = 2'd3;
	localparam logic [LETTER_W-1:0] ASCII_A      = 7'd65;
	localparam logic [SUM_W-1:0]    ALPHA_N      = 12'd26;
	// 6*26 - 65, keeps (letter - 'A') mod 26 non-negative
	localparam logic [SUM_W-1:0]    LETTER_BIAS  = 12'd91;
	// ceil(2^16 / 26), exact quotient for inputs below 4096 after one correction
	localparam logic [SUM_W-1:0]    RECIP_26     = 12'd2521;
	localparam int                  RECIP_SHIFT  = 16;

	// one buffered block of letter values plus the mode it was formed in
	typedef struct packed {
		logic                      two_mode;
		logic [2:0][VAL_W-1:0]     p;
	} hce_block_t;

	// x mod 26 through a reciprocal multiply and one compare-subtract
	function automatic logic [VAL_W-1:0] mod26(input logic [SUM_W-1:0] x);
		logic [2*SUM_W-1:0] prod;
		logic [SUM_W-1:0]   q;
		logic [SUM_W-1:0]   r;
		prod = x * RECIP_26;
		q    = SUM_W'(prod >> RECIP_SHIFT);
		r    = x - SUM_W'(q * ALPHA_N);
		if (r >= ALPHA_N) begin
			r = r - ALPHA_N;
		end
		return r[VAL_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ hdl/hce_front.sv @@
// front end: takes plaintext letters, buffers them and forms full or padded blocks
// depends on hce_pkg
`timescale 1ns / 1ps
`default_nettype none

module hce_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [hce_pkg::BSIZE_W-1:0]   block_size,
	input  wire logic                          in_valid,
	input  wire logic [hce_pkg::LETTER_W-1:0]  letter,
	input  wire logic                          final_letter,
	input  wire logic                          q_full,
	output logic                               in_ready,
	output logic                               push,
	output hce_pkg::hce_block_t                push_block
);
	import hce_pkg::*;

	logic [1:0]       fill_q;
	logic [VAL_W-1:0] held_q [2];
	logic             two_mode;
	logic [1:0]       n_m1;
	logic [1:0]       fill;
	logic [VAL_W-1:0] val;
	logic             accept;
	logic             complete;

	assign two_mode = (block_size == BSIZE_TWO);
	assign n_m1     = two_mode ? 2'd1 : 2'd2;
	// a shrunk block size clips the fill level
	assign fill     = (fill_q > n_m1) ? n_m1 : fill_q;
	assign val      = mod26(SUM_W'(letter) + LETTER_BIAS);

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign complete = final_letter || (fill == n_m1);
	assign push     = accept && complete;

	always_comb begin
		push_block.two_mode = two_mode;
		push_block.p[0] = (fill == 2'd0) ? val : held_q[0];
		push_block.p[1] = (fill == 2'd1) ? val : ((fill == 2'd2) ? held_q[1] : '0);
		push_block.p[2] = (fill == 2'd2) ? val : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			held_q[0] <= '0;
			held_q[1] <= '0;
		end else if (accept) begin
			if (complete) begin
				fill_q <= '0;
			end else begin
				held_q[fill[0]] <= val;
				fill_q          <= fill + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/hce_queue.sv @@
// short block queue between front end and back end
// depends on hce_pkg
`timescale 1ns / 1ps
`default_nettype none

module hce_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire hce_pkg::hce_block_t  push_block,
	input  wire logic                 pop,
	output logic                      full,
	output logic                      empty,
	output hce_pkg::hce_block_t       head
);
	import hce_pkg::*;

	hce_block_t         mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_block;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hdl/hce_back.sv @@
// back end: steps through the rows of each block, multiplies by the key, reduces mod 26
// depends on hce_pkg
`timescale 1ns / 1ps
`default_nettype none

module hce_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [hce_pkg::KEY_W-1:0]     key_matrix,
	input  wire logic                          q_empty,
	input  wire hce_pkg::hce_block_t           head,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [hce_pkg::LETTER_W-1:0]       cipher_letter,
	output logic                               run_end
);
	import hce_pkg::*;

	logic [1:0]       row_q;
	logic [1:0]       last_row;
	logic             row_last;
	logic             issue;
	logic [ROW_W-1:0] key_row;
	logic [SUM_W-1:0] sum;

	logic             valid_s1;
	logic [SUM_W-1:0] sum_s1;
	logic             last_s1;

	logic             out_free;
	logic             s1_ready;

	assign out_free = !out_valid || out_ready;
	assign s1_ready = !valid_s1 || out_free;
	assign issue    = !q_empty && s1_ready;
	assign last_row = head.two_mode ? 2'd1 : 2'd2;
	assign row_last = (row_q == last_row);
	assign pop      = issue && row_last;

	always_comb begin
		unique case (row_q)
			2'd0:    key_row = key_matrix[ROW_W-1:0];
			2'd1:    key_row = key_matrix[2*ROW_W-1:ROW_W];
			default: key_row = key_matrix[3*ROW_W-1:2*ROW_W];
		endcase
	end

	// unused columns of a two-letter block hold zero
	assign sum = SUM_W'(key_row[VAL_W-1:0]) * SUM_W'(head.p[0])
		+ SUM_W'(key_row[2*VAL_W-1:VAL_W]) * SUM_W'(head.p[1])
		+ SUM_W'(key_row[3*VAL_W-1:2*VAL_W]) * SUM_W'(head.p[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (issue) begin
				row_q <= row_last ? 2'd0 : row_q + 2'd1;
			end
			if (s1_ready) begin
				valid_s1 <= issue;
			end
			if (out_free) begin
				out_valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			sum_s1  <= sum;
			last_s1 <= row_last;
		end
		if (out_free && valid_s1) begin
			cipher_letter <= LETTER_W'(mod26(sum_s1)) + ASCII_A;
			run_end       <= last_s1;
		end
	end

endmodule

`default_nettype wire

@@ hdl/hill_cipher_encrypt.sv @@
// top level of the hill cipher encryption block: config registers, front end, queue, back end
// depends on hce_pkg, hce_front, hce_queue, hce_back and hill_cipher_encrypt_macros.svh
// throughput: one plaintext letter per cycle unless the queue is full, one cipher letter
// per cycle unless the output stalls; a size-n block gives n cipher letters, one per key row
// reset: arst_n clears control state, block_size to 3, key_matrix to all zero
`timescale 1ns / 1ps
`default_nettype none

`include "hill_cipher_encrypt_macros.svh"

module hill_cipher_encrypt (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// plaintext stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [7:0]                        s_tdata,  // [6:0] letter, [7] zero
	input  wire logic                              s_tlast,  // final_letter
	// ciphertext stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [7:0]                             m_tdata,  // [6:0] cipher_letter, [7] zero
	output logic                                   m_tlast,  // run_end
	// configuration write channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [hce_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [hce_pkg::KEY_W-1:0]         cfg_data
);
	import hce_pkg::*;

	logic [BSIZE_W-1:0]  block_size_q;
	logic [KEY_W-1:0]    key_matrix_q;

	logic                q_full;
	logic                q_empty;
	logic                q_push;
	logic                q_pop;
	hce_block_t          push_block;
	hce_block_t          q_head;
	logic [LETTER_W-1:0] cipher_letter;

	// config registers: writes must only arrive while the datapath is idle, which the
	// block itself does not enforce; they can be taken every cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= BSIZE_RESET;
			key_matrix_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			// unknown indexes are ignored
			if (cfg_index == REG_BLOCK_SIZE) begin
				block_size_q <= cfg_data[BSIZE_W-1:0];
			end else if (cfg_index == REG_KEY_MATRIX) begin
				key_matrix_q <= cfg_data;
			end
		end
	end

	// front end: letter to value, buffering and padding
	hce_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.block_size   (block_size_q),
		.in_valid     (s_tvalid),
		.letter       (s_tdata[LETTER_W-1:0]),
		.final_letter (s_tlast),
		.q_full       (q_full),
		.in_ready     (s_tready),
		.push         (q_push),
		.push_block   (push_block)
	);

	// decouples block forming from the row stepper so each side stalls on its own
	hce_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_block (push_block),
		.pop        (q_pop),
		.full       (q_full),
		.empty      (q_empty),
		.head       (q_head)
	);

	// back end: one key row per cycle unless stalled, sum registered, mod 26 into the output register
	hce_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.key_matrix    (key_matrix_q),
		.q_empty       (q_empty),
		.head          (q_head),
		.pop           (q_pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.cipher_letter (cipher_letter),
		.run_end       (m_tlast)
	);

	assign m_tdata = {1'b0, cipher_letter};

	// a block only leaves the queue when one is there
	`HCE_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty)
	// the queue is never full and empty at once
	`HCE_ASSERT_IMP(a_queue_sane, 1'b1, !(q_full && q_empty))
	// every cipher letter is an uppercase ascii code
	`HCE_ASSERT_IMP(a_letter_range, m_tvalid,
		(m_tdata[6:0] >= ASCII_A) && (m_tdata[6:0] <= ASCII_A + 7'd25))
	// a full queue refuses the next plaintext transaction
	`HCE_ASSERT_IMP(a_stall_full, q_full, !s_tready)

endmodule

`default_nettype wire

@@ tb/sv/hill_cipher_monitor.sv @@
`timescale 1ns / 1ps
// stream monitor for the hill cipher block: follows config writes, predicts cipher letters
// depends on hce_pkg for widths, register indexes and letter constants

module hill_cipher_monitor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // [6:0] letter, [7] zero
	input  logic                          s_tlast,  // final_letter
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [7:0]                    m_tdata,  // [6:0] cipher_letter, [7] zero
	input  logic                          m_tlast,  // run_end
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [hce_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hce_pkg::KEY_W-1:0]     cfg_data,
	output int                            mismatches,
	output int                            letters_due
);
	import hce_pkg::*;

	typedef struct packed {
		logic [LETTER_W-1:0] cipher_letter;
		logic                run_end;
	} cipher_item_t;

	cipher_item_t        cipher_due[$];
	logic [BSIZE_W-1:0]  block_size_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    held_q [2];
	logic [1:0]          fill_q;

	// fold one plaintext letter into the block, queue cipher letters when it closes
	task automatic encipher_letter(input logic [LETTER_W-1:0] letter, input logic fin);
		int           n;
		int           val;
		int           fill;
		int           sum;
		int           p [3];
		cipher_item_t item;
		n    = (block_size_q == BSIZE_TWO) ? 2 : 3;
		// any 7-bit code folds onto 0..25
		val  = ((int'(letter) - int'(ASCII_A)) % int'(ALPHA_N) + int'(ALPHA_N)) % int'(ALPHA_N);
		fill = int'(fill_q);
		// block shrunk under a partial block: the surplus letter is dropped
		if (fill > n - 1) begin
			fill = n - 1;
		end
		if (fill + 1 < n && !fin) begin
			held_q[fill] = VAL_W'(val);
			fill_q       = 2'(fill + 1);
		end else begin
			for (int c = 0; c < 3; c++) begin
				if (c < fill) begin
					p[c] = int'(held_q[c]);
				end else if (c == fill) begin
					p[c] = val;
				end else begin
					p[c] = 0;
				end
			end
			for (int r = 0; r < n; r++) begin
				sum = 0;
				for (int c = 0; c < n; c++) begin
					sum += int'(key_q[VAL_W * (r * 3 + c) +: VAL_W]) * p[c];
				end
				item.cipher_letter = LETTER_W'(sum % int'(ALPHA_N) + int'(ASCII_A));
				item.run_end       = (r == n - 1);
				cipher_due.push_back(item);
			end
			fill_q = '0;
		end
	endtask

	always @(posedge clk) begin
		cipher_item_t want;
		if (!arst_n) begin
			block_size_q = BSIZE_RESET;
			key_q        = '0;
			held_q[0]    = '0;
			held_q[1]    = '0;
			fill_q       = '0;
			mismatches   = 0;
			cipher_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BLOCK_SIZE: block_size_q = cfg_data[BSIZE_W-1:0];
					REG_KEY_MATRIX: key_q = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				encipher_letter(s_tdata[LETTER_W-1:0], s_tlast);
			end
			if (m_tvalid && m_tready) begin
				if (cipher_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected cipher letter %0d run_end %0b",
							m_tdata[LETTER_W-1:0], m_tlast);
					end
				end else begin
					want = cipher_due.pop_front();
					if (m_tdata[LETTER_W-1:0] !== want.cipher_letter
						|| m_tlast !== want.run_end) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display({"cipher mismatch: expected letter %0d run_end %0b,",
								" got %0d run_end %0b"},
								want.cipher_letter, want.run_end,
								m_tdata[LETTER_W-1:0], m_tlast);
						end
					end
				end
			end
		end
		letters_due <= cipher_due.size();
	end

endmodule

@@ tb/sv/tb_hill_cipher_encrypt.sv @@
`timescale 1ns / 1ps
// top of the hill cipher encryption testbench: clock, reset, stimulus and verdict
// depends on hce_pkg, hill_cipher_encrypt and hill_cipher_monitor

module tb_hill_cipher_encrypt;
	import hce_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	// covers the queue, sum and output registers plus the rows of a 3x3 block
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_ITEMS = 220;

	// indexes past the register file, writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam logic [BSIZE_W-1:0]  BSIZE_ZERO  = 2'd0;
	localparam logic [BSIZE_W-1:0]  BSIZE_ONE   = 2'd1;
	localparam logic [LETTER_W-1:0] LETTER_Z    = ASCII_A + 7'd25;
	localparam logic [KEY_W-1:0]    KEY_ALL_ONE = '1;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata   = '0;   // [6:0] letter, [7] zero
	logic                 s_tlast   = 1'b0; // final_letter
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [7:0]           m_tdata;          // [6:0] cipher_letter, [7] zero
	logic                 m_tlast;          // run_end
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [KEY_W-1:0]     cfg_data  = '0;

	int mismatches;
	int letters_due;
	int cycle_count = 0;
	int rx_stall    = 0;
	// set for whole phases so that some stretches run without any gap
	bit no_idle     = 1'b0;

	hill_cipher_encrypt i_dut (.*);

	// watches all three channels and keeps the failure count
	hill_cipher_monitor i_monitor (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ciphertext side: random stall after each transaction, sometimes also while idle
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_stall = 0;
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				rx_stall = no_idle ? 0 : $urandom_range(0, 4);
			end else if (rx_stall > 0) begin
				rx_stall--;
			end else if (!m_tvalid && !no_idle && $urandom_range(0, 3) == 0) begin
				rx_stall = $urandom_range(1, 4);
			end
			m_tready <= (rx_stall == 0);
		end
	end

	// one plaintext transaction; valid stays high when the next gap is zero
	task automatic send_letter(input logic [LETTER_W-1:0] letter, input logic fin);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, letter};
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop the stream and let every cipher letter drain before a register write
	task automatic settle_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (letters_due != 0) @(posedge clk);
		// a letter that only fills the buffer may still be in flight
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] random_key();
		logic [63:0] bits;
		bits = {$urandom(), $urandom()};
		return bits[KEY_W-1:0];
	endfunction

	// upper data bits are random noise, only the low two bits count
	task automatic write_block_size(input logic [BSIZE_W-1:0] size);
		logic [KEY_W-1:0] value;
		value              = random_key();
		value[BSIZE_W-1:0] = size;
		write_reg(REG_BLOCK_SIZE, value);
	endtask

	// mostly real letters, now and then any 7-bit code
	function automatic logic [LETTER_W-1:0] random_letter();
		if ($urandom_range(0, 7) == 0) begin
			return LETTER_W'($urandom_range(0, 127));
		end
		return LETTER_W'($urandom_range(int'(ASCII_A), int'(LETTER_Z)));
	endfunction

	// unsupported block sizes, one of the two per pick
	function automatic logic [BSIZE_W-1:0] BSIZE_WIDTH_PICK(input int pick);
		return (pick == 6) ? BSIZE_ZERO : BSIZE_ONE;
	endfunction

	initial begin
		int               phase_len;
		int               sent;
		int               pick;
		logic [KEY_W-1:0] key;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 3x3 all-zero key, every cipher letter comes out as 'A'
		send_letter(ASCII_A, 1'b0);
		send_letter(LETTER_Z, 1'b0);
		send_letter(LETTER_Z, 1'b0);
		send_letter(ASCII_A + 7'd12, 1'b1);   // final letter flushes a one-letter block

		// largest key entries, largest letter values, out of range codes
		settle_idle();
		write_reg(REG_KEY_MATRIX, KEY_ALL_ONE);
		write_block_size(BSIZE_RESET);
		send_letter(LETTER_Z, 1'b0);
		send_letter(LETTER_Z, 1'b0);
		send_letter(LETTER_Z, 1'b0);
		send_letter(7'h00, 1'b0);
		send_letter(7'h7f, 1'b1);             // final letter closes a two-letter block

		// 2x2 mode, codes just outside the alphabet, final letter on empty and full blocks
		settle_idle();
		write_block_size(BSIZE_TWO);
		write_reg(REG_KEY_MATRIX, random_key());
		send_letter(ASCII_A - 7'd1, 1'b0);
		send_letter(LETTER_Z + 7'd1, 1'b0);
		send_letter(ASCII_A + 7'd16, 1'b1);
		send_letter(ASCII_A + 7'd1, 1'b0);
		send_letter(ASCII_A + 7'd2, 1'b1);

		// block size shrunk while two letters are held
		settle_idle();
		write_block_size(BSIZE_RESET);
		send_letter(ASCII_A + 7'd3, 1'b0);
		send_letter(ASCII_A + 7'd4, 1'b0);
		settle_idle();
		write_block_size(BSIZE_TWO);
		send_letter(ASCII_A + 7'd5, 1'b0);

		// unsupported sizes act as 3, spare indexes are ignored
		settle_idle();
		write_block_size(BSIZE_ZERO);
		write_reg(REG_SPARE_2, random_key());
		write_reg(REG_SPARE_3, random_key());
		send_letter(ASCII_A + 7'd6, 1'b0);
		send_letter(ASCII_A + 7'd7, 1'b0);
		send_letter(ASCII_A + 7'd8, 1'b0);
		settle_idle();
		write_block_size(BSIZE_ONE);
		send_letter(ASCII_A + 7'd9, 1'b0);
		send_letter(ASCII_A + 7'd10, 1'b0);
		send_letter(ASCII_A + 7'd11, 1'b1);

		// random phases, each with fresh settings and its own idling mode
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			settle_idle();
			no_idle = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 7);
			if (pick < 4) begin
				write_block_size(BSIZE_TWO);
			end else if (pick < 6) begin
				write_block_size(BSIZE_RESET);
			end else begin
				write_block_size(BSIZE_WIDTH_PICK(pick));
			end
			pick = $urandom_range(0, 7);
			if (pick == 0) begin
				key = '0;
			end else if (pick == 1) begin
				key = KEY_ALL_ONE;
			end else begin
				key = random_key();
			end
			write_reg(REG_KEY_MATRIX, key);
			if ($urandom_range(0, 5) == 0) begin
				write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, random_key());
			end
			phase_len = $urandom_range(10, 40);
			for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
				send_letter(random_letter(), $urandom_range(0, 9) == 0);
				sent++;
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (letters_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && letters_due == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/hce_pkg.sv
hdl/hce_front.sv
hdl/hce_queue.sv
hdl/hce_back.sv
hdl/hill_cipher_encrypt.sv
tb/sv/hill_cipher_monitor.sv
tb/sv/tb_hill_cipher_encrypt.sv
